/* design/rrcp_pkg.sv */
// Shared types, codes and the control program of the RAID request command planner.
// Holds the microcode word layout and its read-only program.
// No dependencies.
`default_nettype none

package rrcp_pkg;

  localparam int PC_W      = 6;
  localparam int DISK_W    = 5;
  localparam int BLK_W     = 10;
  localparam int LB_W      = 16;
  localparam int REM_W     = 13;
  localparam int RCP_W     = 25;
  localparam int RCP_SHIFT = 24;

  localparam logic [2:0] LVL_STRIPE        = 3'd0;
  localparam logic [2:0] LVL_MIRROR        = 3'd1;
  localparam logic [2:0] LVL_STRIPE_MIRROR = 3'd2;
  localparam logic [2:0] LVL_FIXED_PARITY  = 3'd3;
  localparam logic [2:0] LVL_ROT_PARITY    = 3'd4;

  localparam logic REG_LEVEL  = 1'b0;
  localparam logic REG_ENABLE = 1'b1;

  typedef enum logic [1:0] {
    MODE_READ, MODE_WRITE, MODE_FAIL, MODE_REPAIR
  } mode_t;

  typedef enum logic [2:0] {
    CMD_STATUS, CMD_READ, CMD_XOR_HOST, CMD_WRITE, CMD_READ_OLD, CMD_XOR_OLD, CMD_PARITY
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK, ST_NOT_ENABLED, ST_RANGE, ST_DISK_FAILED, ST_BAD_DISK, ST_MIRROR_DOWN
  } status_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_WAIT, OP_MUL1, OP_MUL2, OP_FIX, OP_LOC, OP_PSET, OP_JINIT, OP_EMIT, OP_EVENT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_EVENT, C_NOT_EN, C_RANGE, C_MIRROR, C_PARITY, C_READ, C_WRITE,
    C_NUP_D, C_UP_D, C_NUP_BOTH, C_NUP_PART, C_NUP_P
  } cond_t;

  typedef enum logic [2:0] {
    DS_NONE, DS_D, DS_PART, DS_MIRD, DS_P, DS_J
  } dsel_t;

  typedef enum logic [1:0] {
    L_ZERO, L_ONE, L_NOPART, L_JEND
  } last_t;

  typedef enum logic {
    DV_LEVEL, DV_DISKS
  } dv_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
    dv_t              dv;
    cmd_t             cmd;
    status_t          status;
    dsel_t            dsel;
    last_t            last_sel;
  } ctl_t;

  localparam logic [PC_W-1:0] A_WAIT       = 6'd0;
  localparam logic [PC_W-1:0] A_CHK_EVENT  = 6'd1;
  localparam logic [PC_W-1:0] A_CHK_EN     = 6'd2;
  localparam logic [PC_W-1:0] A_CHK_RANGE  = 6'd3;
  localparam logic [PC_W-1:0] A_DIV_MUL    = 6'd4;
  localparam logic [PC_W-1:0] A_DIV_BACK   = 6'd5;
  localparam logic [PC_W-1:0] A_DIV_FIX    = 6'd6;
  localparam logic [PC_W-1:0] A_LOCATE     = 6'd7;
  localparam logic [PC_W-1:0] A_CHK_PARITY = 6'd8;
  localparam logic [PC_W-1:0] A_S_CHK      = 6'd9;
  localparam logic [PC_W-1:0] A_S_RW       = 6'd10;
  localparam logic [PC_W-1:0] A_S_WRITE    = 6'd11;
  localparam logic [PC_W-1:0] A_MIR        = 6'd12;
  localparam logic [PC_W-1:0] A_MIR_RW     = 6'd13;
  localparam logic [PC_W-1:0] A_MIR_W1     = 6'd14;
  localparam logic [PC_W-1:0] A_MIR_WD     = 6'd15;
  localparam logic [PC_W-1:0] A_MIR_WP     = 6'd16;
  localparam logic [PC_W-1:0] A_PAR        = 6'd17;
  localparam logic [PC_W-1:0] A_PAR_BACK   = 6'd18;
  localparam logic [PC_W-1:0] A_PAR_FIX    = 6'd19;
  localparam logic [PC_W-1:0] A_PAR_SET    = 6'd20;
  localparam logic [PC_W-1:0] A_PAR_JINIT  = 6'd21;
  localparam logic [PC_W-1:0] A_PR_UP      = 6'd22;
  localparam logic [PC_W-1:0] A_PR_XOR     = 6'd23;
  localparam logic [PC_W-1:0] A_PW         = 6'd24;
  localparam logic [PC_W-1:0] A_PW_OLD     = 6'd25;
  localparam logic [PC_W-1:0] A_PW_DATA    = 6'd26;
  localparam logic [PC_W-1:0] A_PW_XOR     = 6'd27;
  localparam logic [PC_W-1:0] A_PW_PAR     = 6'd28;
  localparam logic [PC_W-1:0] A_PW_UPD     = 6'd29;
  localparam logic [PC_W-1:0] A_READ       = 6'd30;
  localparam logic [PC_W-1:0] A_FAIL       = 6'd31;
  localparam logic [PC_W-1:0] A_NOT_EN     = 6'd32;
  localparam logic [PC_W-1:0] A_RANGE      = 6'd33;
  localparam logic [PC_W-1:0] A_EVENT      = 6'd34;

  function automatic ctl_t cw(input op_t op, input cond_t cond,
                              input logic [PC_W-1:0] target, input dv_t dv,
                              input cmd_t cmd, input status_t st,
                              input dsel_t ds, input last_t lst);
    ctl_t c;
    c.op       = op;
    c.cond     = cond;
    c.target   = target;
    c.dv       = dv;
    c.cmd      = cmd;
    c.status   = st;
    c.dsel     = ds;
    c.last_sel = lst;
    return c;
  endfunction

  function automatic ctl_t ctl_of(input op_t op, input cond_t cond,
                                  input logic [PC_W-1:0] target, input dv_t dv);
    return cw(op, cond, target, dv, CMD_STATUS, ST_OK, DS_NONE, L_ZERO);
  endfunction

  function automatic ctl_t rrcp_rom(input logic [PC_W-1:0] pc);
    ctl_t c;
    case (pc)
      A_WAIT:       c = ctl_of(OP_WAIT, C_NEVER, A_WAIT, DV_LEVEL);
      A_CHK_EVENT:  c = ctl_of(OP_NOP, C_EVENT, A_EVENT, DV_LEVEL);
      A_CHK_EN:     c = ctl_of(OP_NOP, C_NOT_EN, A_NOT_EN, DV_LEVEL);
      A_CHK_RANGE:  c = ctl_of(OP_NOP, C_RANGE, A_RANGE, DV_LEVEL);
      A_DIV_MUL:    c = ctl_of(OP_MUL1, C_NEVER, A_WAIT, DV_LEVEL);
      A_DIV_BACK:   c = ctl_of(OP_MUL2, C_NEVER, A_WAIT, DV_LEVEL);
      A_DIV_FIX:    c = ctl_of(OP_FIX, C_NEVER, A_WAIT, DV_LEVEL);
      A_LOCATE:     c = ctl_of(OP_LOC, C_MIRROR, A_MIR, DV_LEVEL);
      A_CHK_PARITY: c = ctl_of(OP_NOP, C_PARITY, A_PAR, DV_LEVEL);
      A_S_CHK:      c = ctl_of(OP_NOP, C_NUP_D, A_FAIL, DV_LEVEL);
      A_S_RW:       c = ctl_of(OP_NOP, C_READ, A_READ, DV_LEVEL);
      A_S_WRITE:    c = cw(OP_EMIT, C_ALWAYS, A_WAIT, DV_LEVEL, CMD_WRITE, ST_OK, DS_D, L_ONE);
      A_MIR:        c = ctl_of(OP_NOP, C_NUP_BOTH, A_FAIL, DV_LEVEL);
      A_MIR_RW:     c = ctl_of(OP_NOP, C_READ, A_READ, DV_LEVEL);
      A_MIR_W1:     c = ctl_of(OP_NOP, C_NUP_D, A_MIR_WP, DV_LEVEL);
      A_MIR_WD:     c = cw(OP_EMIT, C_NUP_PART, A_WAIT, DV_LEVEL, CMD_WRITE, ST_OK, DS_D,
                           L_NOPART);
      A_MIR_WP:     c = cw(OP_EMIT, C_ALWAYS, A_WAIT, DV_LEVEL, CMD_WRITE, ST_OK, DS_PART,
                           L_ONE);
      A_PAR:        c = ctl_of(OP_MUL1, C_NEVER, A_WAIT, DV_DISKS);
      A_PAR_BACK:   c = ctl_of(OP_MUL2, C_NEVER, A_WAIT, DV_DISKS);
      A_PAR_FIX:    c = ctl_of(OP_FIX, C_NEVER, A_WAIT, DV_DISKS);
      A_PAR_SET:    c = ctl_of(OP_PSET, C_NEVER, A_WAIT, DV_LEVEL);
      A_PAR_JINIT:  c = ctl_of(OP_JINIT, C_WRITE, A_PW, DV_LEVEL);
      A_PR_UP:      c = ctl_of(OP_NOP, C_UP_D, A_READ, DV_LEVEL);
      A_PR_XOR:     c = cw(OP_EMIT, C_ALWAYS, A_WAIT, DV_LEVEL, CMD_XOR_HOST, ST_OK, DS_J,
                           L_JEND);
      A_PW:         c = ctl_of(OP_NOP, C_NUP_D, A_PW_XOR, DV_LEVEL);
      A_PW_OLD:     c = cw(OP_EMIT, C_NEVER, A_WAIT, DV_LEVEL, CMD_READ_OLD, ST_OK, DS_D,
                           L_ZERO);
      A_PW_DATA:    c = cw(OP_EMIT, C_ALWAYS, A_PW_PAR, DV_LEVEL, CMD_WRITE, ST_OK, DS_D,
                           L_ZERO);
      A_PW_XOR:     c = cw(OP_EMIT, C_NEVER, A_WAIT, DV_LEVEL, CMD_XOR_OLD, ST_OK, DS_J,
                           L_ZERO);
      A_PW_PAR:     c = ctl_of(OP_NOP, C_NUP_P, A_FAIL, DV_LEVEL);
      A_PW_UPD:     c = cw(OP_EMIT, C_ALWAYS, A_WAIT, DV_LEVEL, CMD_PARITY, ST_OK, DS_P,
                           L_ONE);
      A_READ:       c = cw(OP_EMIT, C_ALWAYS, A_WAIT, DV_LEVEL, CMD_READ, ST_OK, DS_MIRD,
                           L_ONE);
      A_FAIL:       c = cw(OP_EMIT, C_ALWAYS, A_WAIT, DV_LEVEL, CMD_STATUS, ST_DISK_FAILED,
                           DS_NONE, L_ONE);
      A_NOT_EN:     c = cw(OP_EMIT, C_ALWAYS, A_WAIT, DV_LEVEL, CMD_STATUS, ST_NOT_ENABLED,
                           DS_NONE, L_ONE);
      A_RANGE:      c = cw(OP_EMIT, C_ALWAYS, A_WAIT, DV_LEVEL, CMD_STATUS, ST_RANGE,
                           DS_NONE, L_ONE);
      A_EVENT:      c = cw(OP_EVENT, C_ALWAYS, A_WAIT, DV_LEVEL, CMD_STATUS, ST_OK,
                           DS_NONE, L_ONE);
      default:      c = ctl_of(OP_NOP, C_ALWAYS, A_WAIT, DV_LEVEL);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/raid_request_command_planner.sv */
// RAID request command planner: a microcoded sequencer that maps array requests to disk
// commands and tracks one up bit per disk. Depends on rrcp_pkg for codes and the program.
//
// Channel   Direction  Handshake              Payload
// config    in/out     psel/penable/pready    paddr, pwdata, prdata
// request   in         in_valid / in_stall    mode, logical_block, disk_number
// command   out        out_valid / out_stall  command, disk_index, disk_block, status, last
//
// An event result, an enable error or a range error is loaded by the status step that its
// check branches to; the checks run in that order. A plain or mirrored disk-failed status
// and the first disk command follow the shared constant divider, the locate step and the
// disk-up checks; the divider takes three steps (estimate multiply, back multiply,
// correction) and runs once or twice per request. Later commands are loaded one per cycle
// while the output does not stall, except for one idle step before the parity update or
// the closing status of a parity write. Reset clears the level, the enable and every disk
// up bit. A stalled output holds the sequencer on its step; a new transaction is taken as
// soon as the last result of the previous one sits in the output register.
`default_nettype none

module raid_request_command_planner
  import rrcp_pkg::*;
#(
  parameter int DISK_COUNT      = 4,
  parameter int BLOCKS_PER_DISK = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        mode,
  input  wire logic [LB_W-1:0]   logical_block,
  input  wire logic [DISK_W-1:0] disk_number,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             command,
  output logic [DISK_W-1:0]      disk_index,
  output logic [BLK_W-1:0]       disk_block,
  output logic [2:0]             status,
  output logic                   last
);

  localparam int IDX_W = $clog2(DISK_COUNT);
  localparam int CAP_W = LB_W + 1;

  localparam logic [DISK_W-1:0] ONE5      = DISK_W'(1);
  localparam logic [DISK_W-1:0] DISK_CNT5 = DISK_W'(DISK_COUNT);
  localparam logic [DISK_W-1:0] HALF5     = DISK_W'(DISK_COUNT / 2);
  localparam logic [PC_W-1:0]   ONE_PC    = PC_W'(1);

  localparam logic [REM_W-1:0] DIV_DISKS = REM_W'(DISK_COUNT);
  localparam logic [REM_W-1:0] DIV_HALF  = REM_W'(DISK_COUNT / 2);
  localparam logic [REM_W-1:0] DIV_DATA  = REM_W'(DISK_COUNT - 1);
  localparam logic [REM_W-1:0] DIV_BPD   = REM_W'(BLOCKS_PER_DISK);
  localparam logic [RCP_W-1:0] RCP_DISKS = RCP_W'((1 << RCP_SHIFT) / DISK_COUNT);
  localparam logic [RCP_W-1:0] RCP_HALF  = RCP_W'((1 << RCP_SHIFT) / (DISK_COUNT / 2));
  localparam logic [RCP_W-1:0] RCP_DATA  = RCP_W'((1 << RCP_SHIFT) / (DISK_COUNT - 1));
  localparam logic [RCP_W-1:0] RCP_BPD   = RCP_W'((1 << RCP_SHIFT) / BLOCKS_PER_DISK);

  localparam logic [CAP_W-1:0] CAP_STRIPE = CAP_W'(BLOCKS_PER_DISK * DISK_COUNT);
  localparam logic [CAP_W-1:0] CAP_MIRROR = CAP_W'(BLOCKS_PER_DISK * (DISK_COUNT / 2));
  localparam logic [CAP_W-1:0] CAP_PARITY = CAP_W'(BLOCKS_PER_DISK * (DISK_COUNT - 1));

  logic [PC_W-1:0]       pc;
  logic [PC_W-1:0]       pc_next;
  ctl_t                  ctl;
  logic [2:0]            raid_level;
  logic                  array_enabled;
  logic [DISK_COUNT-1:0] disk_up;

  mode_t                 mode_r;
  logic [LB_W-1:0]       lb;
  logic [DISK_W-1:0]     dn;
  logic [LB_W-1:0]       a;
  logic [LB_W-1:0]       qe;
  logic [LB_W+REM_W-1:0] prod;
  logic [LB_W-1:0]       q;
  logic [REM_W-1:0]      r;
  logic [DISK_W-1:0]     d;
  logic [LB_W-1:0]       blk;
  logic [DISK_W-1:0]     p;
  logic [DISK_W-1:0]     j;

  logic [REM_W-1:0]       div_val;
  logic [RCP_W-1:0]       div_rcp;
  logic [LB_W+RCP_W-1:0]  est_prod;
  logic [LB_W+REM_W-1:0]  back_prod;
  logic [LB_W+REM_W-1:0]  fix_diff;
  logic [REM_W:0]         rem_est;
  logic [REM_W:0]         rem_sub;
  logic                   rem_over;
  logic [DISK_W-1:0]      p_new;
  logic [DISK_W-1:0]      part;
  logic                   up_d;
  logic                   up_part;
  logic                   up_p;
  logic [DISK_W-1:0]      j_inc;
  logic [DISK_W-1:0]      j_next;
  logic                   j_final;
  logic [CAP_W-1:0]       cap;
  logic                   cond_hit;
  logic                   emitting;
  logic                   fire;
  logic                   step_done;
  logic                   j_more;

  logic                   dn_ok;
  logic [DISK_W-1:0]      dn_m1;
  logic [DISK_W-1:0]      pair_sum;
  logic [DISK_W-1:0]      pair;
  logic [DISK_COUNT-1:0]  dn_mask;
  status_t                ev_status;

  cmd_t                   em_cmd;
  status_t                em_status;
  logic [DISK_W-1:0]      em_disk;
  logic [BLK_W-1:0]       em_blk;
  logic                   em_last;
  logic                   cfg_wr;

  function automatic logic up_at(input logic [DISK_W-1:0] dk,
                                 input logic [DISK_COUNT-1:0] ups);
    logic [DISK_W-1:0] dm1;
    logic              hit;
    dm1 = dk - ONE5;
    hit = 1'b0;
    if (dk != '0 && dk <= DISK_CNT5) begin
      hit = ups[dm1[IDX_W-1:0]];
    end
    return hit;
  endfunction

  assign ctl      = rrcp_rom(pc);
  assign in_stall = (ctl.op != OP_WAIT);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign prdata   = (paddr[2] == REG_LEVEL) ? {29'd0, raid_level} : {31'd0, array_enabled};

  always_comb begin
    div_val = DIV_DISKS;
    div_rcp = RCP_DISKS;
    if (ctl.dv == DV_LEVEL) begin
      case (raid_level)
        LVL_STRIPE: begin
          div_val = DIV_DISKS;
          div_rcp = RCP_DISKS;
        end
        LVL_MIRROR: begin
          div_val = DIV_BPD;
          div_rcp = RCP_BPD;
        end
        LVL_STRIPE_MIRROR: begin
          div_val = DIV_HALF;
          div_rcp = RCP_HALF;
        end
        default: begin
          div_val = DIV_DATA;
          div_rcp = RCP_DATA;
        end
      endcase
    end
  end

  assign est_prod  = a * div_rcp;
  assign back_prod = qe * div_val;
  assign fix_diff  = {{REM_W{1'b0}}, a} - prod;
  assign rem_est   = fix_diff[REM_W:0];
  assign rem_over  = rem_est >= {1'b0, div_val};
  assign rem_sub   = rem_est - {1'b0, div_val};

  assign p_new   = (raid_level == LVL_FIXED_PARITY) ? DISK_CNT5 : r[DISK_W-1:0] + ONE5;
  assign part    = d + HALF5;
  assign up_d    = up_at(d, disk_up);
  assign up_part = up_at(part, disk_up);
  assign up_p    = up_at(p, disk_up);
  assign j_inc   = j + ONE5;
  assign j_next  = (j_inc == d) ? j_inc + ONE5 : j_inc;
  assign j_final = j_next > DISK_CNT5;

  always_comb begin
    case (raid_level)
      LVL_STRIPE:                      cap = CAP_STRIPE;
      LVL_MIRROR, LVL_STRIPE_MIRROR:   cap = CAP_MIRROR;
      LVL_FIXED_PARITY, LVL_ROT_PARITY: cap = CAP_PARITY;
      default:                         cap = '0;
    endcase
  end

  always_comb begin
    case (ctl.cond)
      C_NEVER:    cond_hit = 1'b0;
      C_ALWAYS:   cond_hit = 1'b1;
      C_EVENT:    cond_hit = (mode_r == MODE_FAIL) || (mode_r == MODE_REPAIR);
      C_NOT_EN:   cond_hit = !array_enabled;
      C_RANGE:    cond_hit = {1'b0, lb} >= cap;
      C_MIRROR:   cond_hit = (raid_level == LVL_MIRROR) || (raid_level == LVL_STRIPE_MIRROR);
      C_PARITY:   cond_hit = (raid_level == LVL_FIXED_PARITY) || (raid_level == LVL_ROT_PARITY);
      C_READ:     cond_hit = (mode_r == MODE_READ);
      C_WRITE:    cond_hit = (mode_r == MODE_WRITE);
      C_NUP_D:    cond_hit = !up_d;
      C_UP_D:     cond_hit = up_d;
      C_NUP_BOTH: cond_hit = !up_d && !up_part;
      C_NUP_PART: cond_hit = !up_part;
      C_NUP_P:    cond_hit = !up_p;
      default:    cond_hit = 1'b0;
    endcase
  end

  assign dn_ok    = (dn != '0) && (dn <= DISK_CNT5);
  assign dn_m1    = dn - ONE5;
  assign pair_sum = dn_m1 + HALF5;
  assign pair     = ((pair_sum >= DISK_CNT5) ? pair_sum - DISK_CNT5 : pair_sum) + ONE5;
  assign dn_mask  = DISK_COUNT'(1) << dn_m1[IDX_W-1:0];

  always_comb begin
    ev_status = ST_OK;
    if (!dn_ok) begin
      ev_status = ST_BAD_DISK;
    end else if (!array_enabled) begin
      ev_status = ST_NOT_ENABLED;
    end else if (mode_r == MODE_REPAIR && !up_at(dn, disk_up)) begin
      if ((raid_level == LVL_MIRROR || raid_level == LVL_STRIPE_MIRROR) &&
          !up_at(pair, disk_up)) begin
        ev_status = ST_MIRROR_DOWN;
      end
    end
  end

  always_comb begin
    em_cmd    = ctl.cmd;
    em_status = ctl.status;
    em_blk    = blk[BLK_W-1:0];
    case (ctl.dsel)
      DS_D:    em_disk = d;
      DS_PART: em_disk = part;
      DS_MIRD: em_disk = up_d ? d : part;
      DS_P:    em_disk = p;
      DS_J:    em_disk = j;
      default: em_disk = '0;
    endcase
    case (ctl.last_sel)
      L_ONE:    em_last = 1'b1;
      L_NOPART: em_last = !up_part;
      L_JEND:   em_last = j_final;
      default:  em_last = 1'b0;
    endcase
    if (ctl.op == OP_EVENT) begin
      em_cmd    = CMD_STATUS;
      em_status = ev_status;
      em_last   = 1'b1;
    end
    if (em_cmd == CMD_STATUS) begin
      em_blk = '0;
    end
  end

  assign emitting  = (ctl.op == OP_EMIT) || (ctl.op == OP_EVENT);
  assign fire      = emitting && (!out_valid || !out_stall);
  assign step_done = emitting ? fire : ((ctl.op == OP_WAIT) ? in_valid : 1'b1);
  assign j_more    = (ctl.dsel == DS_J) && !j_final;

  always_comb begin
    pc_next = pc;
    if (step_done && !(emitting && j_more)) begin
      pc_next = cond_hit ? ctl.target : pc + ONE_PC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc            <= A_WAIT;
      out_valid     <= 1'b0;
      raid_level    <= LVL_STRIPE;
      array_enabled <= 1'b0;
      disk_up       <= '0;
    end else begin
      pc <= pc_next;
      if (fire) begin
        out_valid  <= 1'b1;
        command    <= em_cmd;
        disk_index <= em_disk;
        disk_block <= em_blk;
        status     <= em_status;
        last       <= em_last;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (fire && ctl.op == OP_EVENT && dn_ok && array_enabled) begin
        if (mode_r == MODE_FAIL) begin
          disk_up <= disk_up & ~dn_mask;
        end else begin
          disk_up <= disk_up | dn_mask;
        end
      end
      if (cfg_wr) begin
        if (paddr[2] == REG_LEVEL) begin
          raid_level <= pwdata[2:0];
        end else begin
          array_enabled <= pwdata[0];
          disk_up       <= pwdata[0] ? '1 : '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_WAIT: begin
        if (in_valid) begin
          mode_r <= mode_t'(mode);
          lb     <= logical_block;
          dn     <= disk_number;
          a      <= logical_block;
        end
      end
      OP_MUL1: qe <= est_prod[RCP_SHIFT +: LB_W];
      OP_MUL2: prod <= back_prod;
      OP_FIX: begin
        if (rem_over) begin
          q <= qe + LB_W'(1);
          r <= rem_sub[REM_W-1:0];
        end else begin
          q <= qe;
          r <= rem_est[REM_W-1:0];
        end
      end
      OP_LOC: begin
        if (raid_level == LVL_MIRROR) begin
          d   <= q[DISK_W-1:0] + ONE5;
          blk <= LB_W'(r);
        end else begin
          d   <= r[DISK_W-1:0] + ONE5;
          blk <= q;
        end
        a <= q;
      end
      OP_PSET: begin
        p <= p_new;
        if (d >= p_new) begin
          d <= d + ONE5;
        end
      end
      OP_JINIT: j <= (d == ONE5) ? DISK_W'(2) : ONE5;
      OP_EMIT: begin
        if (fire && ctl.dsel == DS_J) begin
          j <= j_next;
        end
      end
      default: ;
    endcase
  end

  a_down_when_disabled: assert property (@(posedge clk) disable iff (rst)
    !array_enabled |-> disk_up == '0)
    else $error("disk up bits set while the array is disabled");

  a_error_is_status_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> command == CMD_STATUS && last && disk_index == '0)
    else $error("error status on a disk command or before the end of a run");

  a_accept_starts_program: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> pc == A_CHK_EVENT)
    else $error("accepted transaction did not start the program");

  a_sweep_skips_data_disk: assert property (@(posedge clk) disable iff (rst)
    ctl.op == OP_EMIT && ctl.dsel == DS_J |-> j != d && j != '0 && j <= DISK_CNT5)
    else $error("disk sweep addresses the data disk or leaves the array");

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for raid_request_command_planner: drives requests and disk
// events, plans the expected disk command runs itself and checks every result transaction.
// Depends on rrcp_pkg for the mode, command and status codes.

module tb_top;
  import rrcp_pkg::*;

  localparam int NDISK = 4;
  localparam int DISK_BLOCKS = 1024;
  localparam int STALL_LIMIT = 2000;
  localparam logic [2:0] ADDR_LEVEL = {REG_LEVEL, 2'b00};
  localparam logic [2:0] ADDR_ENABLE = {REG_ENABLE, 2'b00};
  localparam logic [2:0] LVL_UNDEFINED_TOP = 3'd7;

  typedef struct packed {
    cmd_t              cmd;
    logic [DISK_W-1:0] disk;
    logic [BLK_W-1:0]  blk;
    status_t           st;
    logic              last;
  } disk_cmd_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        mode = '0;
  logic [LB_W-1:0]   logical_block = '0;
  logic [DISK_W-1:0] disk_number = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        command;
  logic [DISK_W-1:0] disk_index;
  logic [BLK_W-1:0]  disk_block;
  logic [2:0]        status;
  logic              last;

  logic [2:0]        model_level = LVL_STRIPE;
  logic              model_enabled = 1'b0;
  logic [NDISK-1:0]  model_up = '0;
  disk_cmd_t         pending_cmds[$];
  logic [7:0]        levels_seen = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;
  int cmds_checked = 0;
  int failures = 0;
  int idle_cycles = 0;

  raid_request_command_planner #(
    .DISK_COUNT      (NDISK),
    .BLOCKS_PER_DISK (DISK_BLOCKS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .logical_block (logical_block),
    .disk_number   (disk_number),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .command       (command),
    .disk_index    (disk_index),
    .disk_block    (disk_block),
    .status        (status),
    .last          (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit disk_alive(int d);
    if (d < 1 || d > NDISK) return 1'b0;
    return model_up[d-1];
  endfunction

  function automatic int array_blocks();
    case (model_level)
      LVL_STRIPE: return DISK_BLOCKS * NDISK;
      LVL_MIRROR, LVL_STRIPE_MIRROR: return DISK_BLOCKS * (NDISK / 2);
      LVL_FIXED_PARITY, LVL_ROT_PARITY: return DISK_BLOCKS * (NDISK - 1);
      default: return 0;
    endcase
  endfunction

  function automatic void queue_cmd(cmd_t c, int d, int b, status_t s);
    disk_cmd_t e;
    e.cmd = c;
    e.disk = DISK_W'(d);
    e.blk = BLK_W'(b);
    e.st = s;
    e.last = 1'b0;
    pending_cmds.push_back(e);
  endfunction

  function automatic void queue_status(status_t s);
    queue_cmd(CMD_STATUS, 0, 0, s);
  endfunction

  function automatic void plan_request(bit wr, int lb);
    int d, blk, p, j, half;
    half = NDISK / 2;
    if (!model_enabled) begin
      queue_status(ST_NOT_ENABLED);
      return;
    end
    if (lb >= array_blocks()) begin
      queue_status(ST_RANGE);
      return;
    end
    case (model_level)
      LVL_STRIPE: begin
        d = lb % NDISK + 1;
        blk = lb / NDISK;
        if (!disk_alive(d)) queue_status(ST_DISK_FAILED);
        else queue_cmd(wr ? CMD_WRITE : CMD_READ, d, blk, ST_OK);
      end
      LVL_MIRROR, LVL_STRIPE_MIRROR: begin
        if (model_level == LVL_MIRROR) begin
          d = lb / DISK_BLOCKS + 1;
          blk = lb % DISK_BLOCKS;
        end else begin
          d = lb % half + 1;
          blk = lb / half;
        end
        if (!disk_alive(d) && !disk_alive(d + half)) begin
          queue_status(ST_DISK_FAILED);
        end else if (!wr) begin
          queue_cmd(CMD_READ, disk_alive(d) ? d : d + half, blk, ST_OK);
        end else begin
          if (disk_alive(d)) queue_cmd(CMD_WRITE, d, blk, ST_OK);
          if (disk_alive(d + half)) queue_cmd(CMD_WRITE, d + half, blk, ST_OK);
        end
      end
      default: begin
        d = lb % (NDISK - 1) + 1;
        blk = lb / (NDISK - 1);
        p = (model_level == LVL_FIXED_PARITY) ? NDISK : blk % NDISK + 1;
        if (d >= p) d++;
        if (!wr) begin
          if (disk_alive(d)) begin
            queue_cmd(CMD_READ, d, blk, ST_OK);
          end else begin
            for (j = 1; j <= NDISK; j++)
              if (j != d) queue_cmd(CMD_XOR_HOST, j, blk, ST_OK);
          end
        end else begin
          if (disk_alive(d)) begin
            queue_cmd(CMD_READ_OLD, d, blk, ST_OK);
            queue_cmd(CMD_WRITE, d, blk, ST_OK);
          end else begin
            for (j = 1; j <= NDISK; j++)
              if (j != d) queue_cmd(CMD_XOR_OLD, j, blk, ST_OK);
          end
          if (!disk_alive(p)) queue_status(ST_DISK_FAILED);
          else queue_cmd(CMD_PARITY, p, blk, ST_OK);
        end
      end
    endcase
  endfunction

  function automatic void plan_event(bit repair, int dn);
    status_t st;
    int pair;
    st = ST_OK;
    if (dn < 1 || dn > NDISK) begin
      st = ST_BAD_DISK;
    end else if (!model_enabled) begin
      st = ST_NOT_ENABLED;
    end else if (!repair) begin
      model_up[dn-1] = 1'b0;
    end else if (!model_up[dn-1]) begin
      model_up[dn-1] = 1'b1;
      if (model_level == LVL_MIRROR || model_level == LVL_STRIPE_MIRROR) begin
        pair = (dn - 1 + NDISK / 2) % NDISK + 1;
        if (!model_up[pair-1]) st = ST_MIRROR_DOWN;
      end
    end
    queue_status(st);
  endfunction

  function automatic void plan_transaction(mode_t m, int lb, int dn);
    disk_cmd_t e;
    if (m == MODE_FAIL || m == MODE_REPAIR) plan_event(m == MODE_REPAIR, dn);
    else plan_request(m == MODE_WRITE, lb);
    e = pending_cmds.pop_back();
    e.last = 1'b1;
    pending_cmds.push_back(e);
    levels_seen[model_level] = 1'b1;
  endfunction

  task automatic send_item(mode_t m, int lb, int dn);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    logical_block <= LB_W'(lb);
    disk_number <= DISK_W'(dn);
    do @(posedge clk); while (in_stall);
    plan_transaction(m, lb, dn);
    items_sent++;
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, int value);
    pause_until_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_LEVEL) begin
      model_level = 3'(value);
    end else begin
      model_enabled = value[0];
      model_up = model_enabled ? '1 : '0;
    end
  endtask

  task automatic send_random_item();
    int r, lb, dn, cap;
    mode_t m;
    r = $urandom_range(0, 99);
    m = (r < 38) ? MODE_READ : (r < 76) ? MODE_WRITE : (r < 88) ? MODE_FAIL : MODE_REPAIR;
    cap = array_blocks();
    if (cap == 0 || $urandom_range(0, 9) == 0) lb = $urandom_range(0, 65535);
    else lb = $urandom_range(0, cap - 1);
    if ($urandom_range(0, 9) == 0) dn = $urandom_range(0, 31);
    else dn = $urandom_range(1, NDISK);
    send_item(m, lb, dn);
  endtask

  // Reset state: array disabled, so requests and valid events report not enabled.
  task automatic test_disabled_array();
    send_item(MODE_READ, 0, 0);
    send_item(MODE_FAIL, 0, 0);
    send_item(MODE_REPAIR, 0, 31);
    send_item(MODE_FAIL, 0, 2);
  endtask

  task automatic test_undefined_level();
    write_reg(ADDR_LEVEL, LVL_UNDEFINED_TOP);
    write_reg(ADDR_ENABLE, 1);
    send_item(MODE_READ, 0, 0);
    send_item(MODE_REPAIR, 0, 1);
  endtask

  task automatic test_stripe_map();
    write_reg(ADDR_LEVEL, LVL_STRIPE);
    send_item(MODE_READ, 0, 0);
    send_item(MODE_WRITE, 4095, 0);
    send_item(MODE_READ, 4096, 0);
    send_item(MODE_WRITE, 65535, 0);
    send_item(MODE_FAIL, 0, 4);
    send_item(MODE_READ, 3, 0);
    send_item(MODE_REPAIR, 0, 4);
  endtask

  task automatic test_mirror_map();
    write_reg(ADDR_LEVEL, LVL_MIRROR);
    send_item(MODE_FAIL, 0, 1);
    send_item(MODE_READ, 0, 0);
    send_item(MODE_WRITE, 0, 0);
    send_item(MODE_FAIL, 0, 3);
    send_item(MODE_WRITE, 0, 0);
    send_item(MODE_REPAIR, 0, 1);
  endtask

  task automatic test_parity_map();
    write_reg(ADDR_ENABLE, 1);
    write_reg(ADDR_LEVEL, LVL_ROT_PARITY);
    send_item(MODE_FAIL, 0, 2);
    send_item(MODE_READ, 0, 0);
    send_item(MODE_WRITE, 0, 0);
    send_item(MODE_WRITE, 3, 0);
    write_reg(ADDR_LEVEL, LVL_FIXED_PARITY);
    send_item(MODE_WRITE, 3071, 0);
    send_item(MODE_READ, 3072, 0);
    write_reg(ADDR_ENABLE, 0);
    send_item(MODE_READ, 0, 0);
  endtask

  task automatic test_random_mix(int settings, int per_setting);
    int lvl;
    for (int s = 0; s < settings; s++) begin
      if ($urandom_range(0, 9) != 0) lvl = $urandom_range(LVL_STRIPE, LVL_ROT_PARITY);
      else lvl = $urandom_range(LVL_ROT_PARITY + 1, LVL_UNDEFINED_TOP);
      write_reg(ADDR_LEVEL, lvl);
      write_reg(ADDR_ENABLE, ($urandom_range(0, 7) == 0) ? 0 : 1);
      for (int i = 0; i < per_setting; i++) begin
        if (s == 1 && i == per_setting / 2) pause_until_drained();
        send_random_item();
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    disk_cmd_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = disk_cmd_t'({command, disk_index, disk_block, status, last});
      if (pending_cmds.size() == 0) begin
        failures++;
        $display("%0t: unexpected result: cmd %0d disk %0d block %0d status %0d last %0d",
                 $time, command, disk_index, disk_block, status, last);
      end else begin
        want = pending_cmds.pop_front();
        cmds_checked++;
        if (got !== want) begin
          failures++;
          $display({"%0t: mismatch: expected cmd %0d disk %0d block %0d status %0d last %0d,",
                    " actual cmd %0d disk %0d block %0d status %0d last %0d"},
                   $time, want.cmd, want.disk, want.blk, want.st, want.last,
                   command, disk_index, disk_block, status, last);
        end
      end
    end
    out_stall <= (recv_idle_pct > 0) && ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, pending_cmds.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 9;
    recv_idle_pct = 80;
    test_disabled_array();
    test_undefined_level();
    test_stripe_map();
    test_mirror_map();
    test_parity_map();
    test_random_mix(4, 25);

    send_idle_pct = 80;
    recv_idle_pct = 9;
    test_random_mix(4, 27);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(4, 28);

    pause_until_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d requests and disk events; checked %0d command results.",
             items_sent, cmds_checked);
    $display("RAID levels exercised (bit per level): %b, mismatches: %0d.",
             levels_seen, failures);
    if (failures == 0 && pending_cmds.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
